[hdl/isl_pkg.sv]
`timescale 1ns / 1ps

package isl_pkg;

    // List geometry
    localparam int CAPACITY  = 64;
    localparam int WORD_BITS = 32;

    // Fixed field widths of the channels
    localparam int ACT_W       = 3;
    localparam int POS_W       = 7;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int ENTRY_CNT_W = 7;

    // Internal widths
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [ACT_W-1:0] {
        ACT_INS_AT     = 3'd0,
        ACT_INS_FIRST  = 3'd1,
        ACT_INS_LAST   = 3'd2,
        ACT_INS_SORTED = 3'd3,
        ACT_POP_AT     = 3'd4,
        ACT_POP_FIRST  = 3'd5,
        ACT_POP_LAST   = 3'd6
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // What a cell loads on the next edge
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_BELOW,
        CELL_FROM_ABOVE
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd cmd;
        logic      capture;
        logic      desc;
    } t_cell_ctrl;

endpackage

[hdl/isl_if.sv]
`timescale 1ns / 1ps

// Request channel: one item per list action
interface isl_in_if;
    logic                          valid;
    logic                          ready;
    logic [isl_pkg::ACT_W-1:0]     action;
    logic [isl_pkg::POS_W-1:0]     position;
    logic [isl_pkg::VALUE_W-1:0]   value;

    modport source (output valid, action, position, value, input ready);
    modport sink   (input valid, action, position, value, output ready);
endinterface

// Result channel: one item per accepted request
interface isl_out_if;
    logic                              valid;
    logic                              ready;
    logic [isl_pkg::VALUE_W-1:0]       popped_value;
    logic [isl_pkg::STATUS_W-1:0]      status;
    logic [isl_pkg::ENTRY_CNT_W-1:0]   entry_count;
    logic                              is_empty;

    modport source (output valid, popped_value, status, entry_count, is_empty, input ready);
    modport sink   (input valid, popped_value, status, entry_count, is_empty, output ready);
endinterface

[hdl/isl_cell.sv]
`timescale 1ns / 1ps

// One list slot: holds a word, shifts with its neighbors, flags whether
// a sorted insert must land at or below it.
module isl_cell (
    input  logic                i_clk,
    input  isl_pkg::t_cell_ctrl i_ctrl,
    input  isl_pkg::t_word      i_below,
    input  isl_pkg::t_word      i_above,
    input  isl_pkg::t_word      i_new,
    input  isl_pkg::t_word      i_key,
    output isl_pkg::t_word      o_word,
    output logic                o_past
);
    import isl_pkg::*;

    t_word r_word;
    t_word n_word;
    logic  r_past;

    // Next word from the shift command
    always_comb begin
        unique case (i_ctrl.cmd)
            CELL_LOAD:       n_word = i_new;
            CELL_FROM_BELOW: n_word = i_below;
            CELL_FROM_ABOVE: n_word = i_above;
            default:         n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    // Key compare, taken when a request is accepted
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_past <= i_ctrl.desc ? (r_word < i_key) : (r_word > i_key);
        end
    end

    assign o_word = r_word;
    assign o_past = r_past;

endmodule

[hdl/indexed_sorted_list_store.sv]
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY words held in a row of shifting cells.
//
// i_in carries one action per item: insert at an index, first, last or in
// sorted (stable) position, or pop at an index, first or last. o_out returns
// exactly one item per request: popped word, status, count and empty flag.
// i_cfg_we / i_cfg_wdata write the sort direction (1 = descending); write it
// only while no request is in flight.
//
// Timing: a request is registered and compared in every cell at the edge
// on which it is accepted. Once the output register is empty or its result
// is being taken, the cells shift and the result is loaded into the output
// register at the same edge. No new request is taken until the pending one
// has shifted: first the per-cell key compare, then the row-wide shift.
// If the receiver stalls with a result waiting, the next request is still
// accepted and compared, and its shift waits until the result is taken.
// Reset (synchronous, active low) empties the list, clears both channels
// and sets ascending order; cell contents are not cleared.
module indexed_sorted_list_store (
    input  logic            i_clk,
    input  logic            i_rst_n,
    isl_in_if.sink          i_in,
    isl_out_if.source       o_out,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata
);
    import isl_pkg::*;

    // Control and request registers
    logic                r_busy;
    logic                n_busy;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_sort_desc;
    t_action             r_act;
    logic [POS_W-1:0]    r_pos;
    t_word               r_value;

    // Result registers
    logic [VALUE_W-1:0]  r_out_popped;
    t_status             r_out_status;
    logic [CNT_W-1:0]    r_out_count;

    // Cell row
    t_word               w_word [CAPACITY];
    logic [CAPACITY-1:0] w_past;
    t_cell_ctrl          w_ctrl [CAPACITY];

    logic                in_acc;
    logic                fire;
    logic                do_upd;
    logic                is_ins;
    logic                is_pop;
    logic                is_sorted;
    logic [CMP_W-1:0]    k;
    t_status             status;
    logic [CAPACITY-1:0] slot_x;
    logic [CAPACITY-1:0] sorted_ge;
    logic [CAPACITY-1:0] ge;
    logic [CAPACITY-1:0] at;
    t_word               popped_word;

    assign in_acc      = i_in.valid & i_in.ready;
    assign i_in.ready  = ~r_busy;
    assign fire        = r_busy & (~r_out_valid | o_out.ready);

    // Decode the pending action
    always_comb begin
        is_ins    = 1'b0;
        is_pop    = 1'b0;
        is_sorted = 1'b0;
        k         = '0;
        case (r_act)
            ACT_INS_AT: begin
                is_ins = 1'b1;
                k      = CMP_W'(r_pos);
            end
            ACT_INS_FIRST: begin
                is_ins = 1'b1;
            end
            ACT_INS_LAST: begin
                is_ins = 1'b1;
                k      = CMP_W'(r_count);
            end
            ACT_INS_SORTED: begin
                is_ins    = 1'b1;
                is_sorted = 1'b1;
            end
            ACT_POP_AT: begin
                is_pop = 1'b1;
                k      = CMP_W'(r_pos);
            end
            ACT_POP_FIRST: begin
                is_pop = 1'b1;
            end
            ACT_POP_LAST: begin
                is_pop = 1'b1;
                k      = CMP_W'(r_count) - CMP_W'(1);
            end
            default: ;
        endcase
    end

    // Status: full/empty checks come before the index check
    always_comb begin
        status = ST_OK;
        if (is_ins) begin
            if (r_count == CNT_W'(CAPACITY)) begin
                status = ST_FULL;
            end else if (r_act == ACT_INS_AT && CMP_W'(r_pos) > CMP_W'(r_count)) begin
                status = ST_RANGE;
            end
        end else if (is_pop) begin
            if (r_count == '0) begin
                status = ST_EMPTY;
            end else if (r_act == ACT_POP_AT && CMP_W'(r_pos) >= CMP_W'(r_count)) begin
                status = ST_RANGE;
            end
        end
    end

    // Sorted slot: first cell past the key, or the first unused cell.
    // x | -x sets every bit from the lowest set bit upward.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            slot_x[i] = w_past[i] | (CNT_W'(i) >= r_count);
        end
        sorted_ge = slot_x | (~slot_x + CAPACITY'(1));
    end

    // Per-cell "at or above target" mask and target cell
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            ge[i] = is_sorted ? sorted_ge[i] : (CMP_W'(i) >= k);
        end
        at = ge & ~{ge[CAPACITY-2:0], 1'b0};
    end

    // Word leaving on a pop
    always_comb begin
        popped_word = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            popped_word = popped_word | (at[i] ? w_word[i] : '0);
        end
    end

    assign do_upd = fire & (status == ST_OK);

    // Shift commands for the row
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_ctrl[i].capture = in_acc;
            w_ctrl[i].desc    = r_sort_desc;
            w_ctrl[i].cmd     = CELL_HOLD;
            if (do_upd && is_ins) begin
                if (at[i]) begin
                    w_ctrl[i].cmd = CELL_LOAD;
                end else if (ge[i]) begin
                    w_ctrl[i].cmd = CELL_FROM_BELOW;
                end
            end else if (do_upd && is_pop && ge[i]) begin
                w_ctrl[i].cmd = CELL_FROM_ABOVE;
            end
        end
    end

    // Cell row; the ends feed back their own word
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        isl_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl[g]),
            .i_below ((g == 0) ? w_word[g] : w_word[(g == 0) ? 0 : g - 1]),
            .i_above ((g == CAPACITY - 1) ? w_word[g]
                                          : w_word[(g == CAPACITY - 1) ? g : g + 1]),
            .i_new   (r_value),
            .i_key   (WORD_BITS'(i_in.value)),
            .o_word  (w_word[g]),
            .o_past  (w_past[g])
        );
    end

    // Next control state
    always_comb begin
        n_busy      = r_busy;
        n_out_valid = r_out_valid;
        n_count     = r_count;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (fire) begin
            n_busy      = 1'b0;
            n_out_valid = 1'b1;
        end
        if (in_acc) begin
            n_busy = 1'b1;
        end
        if (do_upd && is_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_upd && is_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_sort_desc <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            if (i_cfg_we) begin
                r_sort_desc <= i_cfg_wdata;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_act   <= t_action'(i_in.action);
            r_pos   <= i_in.position;
            r_value <= WORD_BITS'(i_in.value);
        end
        if (fire) begin
            r_out_popped <= (is_pop && status == ST_OK) ? VALUE_W'(popped_word) : '0;
            r_out_status <= status;
            r_out_count  <= n_count;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.popped_value = r_out_popped;
    assign o_out.status       = r_out_status;
    assign o_out.entry_count  = ENTRY_CNT_W'(r_out_count);
    assign o_out.is_empty     = (r_out_count == '0);

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_upd && is_ins |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow the list");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_upd && is_pop |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("pop did not shrink the list");

    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid && r_out_count == r_count)
        else $error("result not presented after update");

    a_one_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> $onehot0(at))
        else $error("more than one target cell");

endmodule

[tb/indexed_sorted_list_store_test.sv]
`timescale 1ns / 1ps

module indexed_sorted_list_store_test;
    import isl_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 4;
    localparam int PHASE_ITEMS  = 275;
    localparam int SETTLE       = 4;

    // Action code with no enum member; the block must treat it as a no-op
    localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

    // Stretch kinds of the random part
    localparam int GROW  = 0;
    localparam int SHRINK = 1;
    localparam int MIXED = 2;

    typedef struct packed {
        t_word                   popped;
        t_status                 status;
        logic [ENTRY_CNT_W-1:0]  entries;
        logic                    empty;
    } t_list_result;

    // Shadow list plus queue of results still owed by the block
    class list_scoreboard;
        t_word        cells[CAPACITY];
        int           fill;
        bit           descending;
        t_list_result owed_q[$];
        int           requests;
        int           checked;
        int           failures;
        int           peak_fill;
        int           outcome[4];

        function new();
            fill = 0;
            descending = 0;
            requests = 0;
            checked = 0;
            failures = 0;
            peak_fill = 0;
            foreach (outcome[i]) outcome[i] = 0;
        endfunction

        function void write_order(bit d);
            descending = d;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Open a slot at 'at' and shift the upper entries up
        function t_status put_word(int at, t_word w);
            if (fill >= CAPACITY) return ST_FULL;
            if (at > fill) return ST_RANGE;
            for (int i = fill; i > at; i--) cells[i] = cells[i-1];
            cells[at] = w;
            fill++;
            return ST_OK;
        endfunction

        // Remove the entry at 'at' and close the gap
        function t_status take_word(int at, output t_word got);
            got = '0;
            if (fill == 0) return ST_EMPTY;
            if (at >= fill) return ST_RANGE;
            got = cells[at];
            for (int i = at; i < fill - 1; i++) cells[i] = cells[i+1];
            fill--;
            return ST_OK;
        endfunction

        function void note_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                                   logic [VALUE_W-1:0] val);
            t_list_result r;
            t_word        w;
            t_word        got;
            int           slot;
            w = t_word'(val);
            got = '0;
            r.status = ST_OK;
            case (act)
                ACT_INS_AT:     r.status = put_word(int'(pos), w);
                ACT_INS_FIRST:  r.status = put_word(0, w);
                ACT_INS_LAST:   r.status = put_word(fill, w);
                ACT_INS_SORTED: begin
                    // stable: first entry strictly past the key
                    slot = fill;
                    for (int i = 0; i < fill; i++) begin
                        if (descending ? (cells[i] < w) : (cells[i] > w)) begin
                            slot = i;
                            break;
                        end
                    end
                    r.status = put_word(slot, w);
                end
                ACT_POP_AT:     r.status = take_word(int'(pos), got);
                ACT_POP_FIRST:  r.status = take_word(0, got);
                ACT_POP_LAST:   r.status = take_word(fill - 1, got);
                default:        r.status = ST_OK;
            endcase
            r.popped  = got;
            r.entries = ENTRY_CNT_W'(fill);
            r.empty   = (fill == 0);
            requests++;
            outcome[r.status]++;
            if (fill > peak_fill) peak_fill = fill;
            owed_q.push_back(r);
        endfunction

        function void check_result(t_list_result got);
            t_list_result want;
            checked++;
            if (owed_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("result with nothing owed: ",
                             "popped %h status %0d count %0d empty %0b",
                             got.popped, got.status, got.entries, got.empty);
                return;
            end
            want = owed_q.pop_front();
            if (got.popped !== want.popped || got.status !== want.status ||
                got.entries !== want.entries || got.empty !== want.empty) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch on result %0d: ", checked,
                             "want popped %h status %0d count %0d empty %0b, ",
                             want.popped, want.status, want.entries, want.empty,
                             "got popped %h status %0d count %0d empty %0b",
                             got.popped, got.status, got.entries, got.empty);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    bit   steady = 1'b0;
    int   cycles = 0;

    isl_in_if  in_ch();
    isl_out_if out_ch();

    list_scoreboard sb = new();

    indexed_sorted_list_store dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF clk = ~clk;

    // Known values on every input from time zero
    initial begin
        in_ch.valid    = 1'b0;
        in_ch.action   = '0;
        in_ch.position = '0;
        in_ch.value    = '0;
        out_ch.ready   = 1'b0;
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Observe both handshakes and register writes at each edge
    always @(posedge clk) begin : observe
        t_list_result seen;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                seen.popped  = out_ch.popped_value;
                seen.status  = t_status'(out_ch.status);
                seen.entries = out_ch.entry_count;
                seen.empty   = out_ch.is_empty;
                sb.check_result(seen);
            end
            if (in_ch.valid && in_ch.ready)
                sb.note_request(in_ch.action, in_ch.position, in_ch.value);
            if (cfg_we)
                sb.write_order(cfg_wdata);
        end
    end

    // Result side: random stalls before each item
    initial begin : drain_results
        int stall;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    // Offer one request item and hold it until taken
    task automatic send_item(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                             logic [VALUE_W-1:0] val);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.action   <= act;
        in_ch.position <= pos;
        in_ch.value    <= val;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Stop offering and wait for every owed result
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_order(bit d);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= d;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        int                 kind;
        int                 span;
        int                 done;
        int                 roll;
        logic [ACT_W-1:0]   act;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] val;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pops, range errors, appends, no-op, sorted inserts
        set_order(1'b0);
        send_item(ACT_POP_FIRST, 7'd0, 32'd0);
        send_item(ACT_POP_LAST, 7'd0, 32'd0);
        send_item(ACT_POP_AT, 7'd0, 32'd0);
        send_item(ACT_INS_AT, 7'd1, 32'd7);
        send_item(ACT_INS_AT, 7'd0, 32'hFFFF_FFFF);
        send_item(ACT_INS_FIRST, 7'd0, 32'h0000_0000);
        send_item(ACT_INS_LAST, 7'd0, 32'h8000_0000);
        send_item(ACT_INS_SORTED, 7'd0, 32'h0000_0005);
        send_item(ACT_INS_AT, 7'd4, 32'hAAAA_5555);
        send_item(ACT_INS_AT, 7'd127, 32'd1);
        send_item(ACT_POP_AT, 7'd5, 32'd0);
        send_item(ACT_POP_AT, 7'd127, 32'd0);
        send_item(ACT_UNUSED, 7'd127, 32'hFFFF_FFFF);
        send_item(ACT_POP_AT, 7'd2, 32'd0);
        send_item(ACT_POP_FIRST, 7'd0, 32'd0);
        send_item(ACT_POP_LAST, 7'd0, 32'd0);
        send_item(ACT_POP_LAST, 7'd0, 32'd0);
        send_item(ACT_POP_LAST, 7'd0, 32'd0);
        send_item(ACT_INS_SORTED, 7'd0, 32'd9);
        send_item(ACT_INS_SORTED, 7'd0, 32'd3);
        send_item(ACT_INS_SORTED, 7'd0, 32'd9);
        send_item(ACT_INS_SORTED, 7'd0, 32'hFFFF_FFFF);
        send_item(ACT_INS_SORTED, 7'd0, 32'd0);
        send_item(ACT_POP_FIRST, 7'd0, 32'd0);
        send_item(ACT_POP_LAST, 7'd0, 32'd0);

        // Random: phases alternate the sort order; stretches bias the fill level
        for (int ph = 0; ph < PHASES; ph++) begin
            set_order(ph % 2 == 0);
            done = 0;
            for (int st = 0; done < PHASE_ITEMS; st++) begin
                kind   = (st == 0) ? GROW : (st == 1) ? SHRINK : $urandom_range(0, 2);
                span   = $urandom_range(40, 90);
                steady = ($urandom_range(0, 3) == 0);
                for (int k = 0; k < span && done < PHASE_ITEMS; k++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 3) begin
                        act = ACT_UNUSED;
                    end else if ((kind == GROW && roll < 88) ||
                                 (kind == SHRINK && roll >= 88) ||
                                 (kind == MIXED && roll < 52)) begin
                        case ($urandom_range(0, 4))
                            0:       act = ACT_INS_AT;
                            1:       act = ACT_INS_FIRST;
                            2:       act = ACT_INS_LAST;
                            default: act = ACT_INS_SORTED;
                        endcase
                    end else begin
                        case ($urandom_range(0, 2))
                            0:       act = ACT_POP_AT;
                            1:       act = ACT_POP_FIRST;
                            default: act = ACT_POP_LAST;
                        endcase
                    end
                    // mostly plausible indexes, some wild ones
                    pos = ($urandom_range(0, 6) == 0) ? POS_W'($urandom_range(0, 127))
                                                      : POS_W'($urandom_range(0, 64));
                    case ($urandom_range(0, 9))
                        0:       val = 32'h0000_0000;
                        1:       val = 32'hFFFF_FFFF;
                        2, 3, 4: val = VALUE_W'($urandom_range(0, 15));
                        default: val = $urandom();
                    endcase
                    send_item(act, pos, val);
                    done++;
                end
            end
        end
        steady = 1'b0;

        wait_idle();
        $display("Drove %0d list actions, checked %0d results in both sort orders; ",
                 sb.requests, sb.checked,
                 "peak fill %0d of %0d.", sb.peak_fill, CAPACITY);
        $display("Outcomes: %0d ok, %0d full, %0d empty, %0d out of range; %0d mismatches.",
                 sb.outcome[ST_OK], sb.outcome[ST_FULL], sb.outcome[ST_EMPTY],
                 sb.outcome[ST_RANGE], sb.failures);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
